FILE: hw/rtl/expression_token_lexer_unit_macros.svh
// Assertion helpers for the lexer checker.
`ifndef EXPRESSION_TOKEN_LEXER_UNIT_MACROS_SVH
`define EXPRESSION_TOKEN_LEXER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ETL_ASSERT_IMP(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lexer assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ETL_ASSERT_NXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lexer assertion failed");

`endif

FILE: hw/rtl/etl_pkg.sv
package etl_pkg;

    localparam int POSITION_BITS_DEFAULT = 16;
    localparam int TOKEN_FIFO_DEPTH      = 4;

    // token kinds
    localparam logic [4:0] KIND_NAME     = 5'd0;
    localparam logic [4:0] KIND_CONST    = 5'd1;
    localparam logic [4:0] KIND_LSHIFT   = 5'd2;
    localparam logic [4:0] KIND_RSHIFT   = 5'd3;
    localparam logic [4:0] KIND_POWER    = 5'd4;
    localparam logic [4:0] KIND_PLUS     = 5'd5;
    localparam logic [4:0] KIND_MINUS    = 5'd6;
    localparam logic [4:0] KIND_ASTERISK = 5'd7;
    localparam logic [4:0] KIND_SLASH    = 5'd8;
    localparam logic [4:0] KIND_LPAREN   = 5'd9;
    localparam logic [4:0] KIND_RPAREN   = 5'd10;
    localparam logic [4:0] KIND_CARET    = 5'd11;
    localparam logic [4:0] KIND_PIPE     = 5'd12;
    localparam logic [4:0] KIND_AMP      = 5'd13;
    localparam logic [4:0] KIND_TILDE    = 5'd14;
    localparam logic [4:0] KIND_LANGLE   = 5'd15;
    localparam logic [4:0] KIND_RANGLE   = 5'd16;
    localparam logic [4:0] KIND_BANG     = 5'd17;
    localparam logic [4:0] KIND_COMMA    = 5'd18;
    localparam logic [4:0] KIND_HASH     = 5'd19;
    localparam logic [4:0] KIND_INVALID  = 5'd20;
    localparam logic [4:0] KIND_END      = 5'd21;

    // number bases
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_HEX = 2'd1;
    localparam logic [1:0] BASE_BIN = 2'd2;

    // prefix and name characters
    localparam logic [7:0] CHAR_DOLLAR     = 8'h24;
    localparam logic [7:0] CHAR_PERCENT    = 8'h25;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_DOT        = 8'h2E;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } lex_in_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [1:0]  number_base;
        logic [15:0] token_start;
        logic [15:0] token_length;
        logic        last_of_run;
    } lex_out_t;

    typedef struct packed {
        logic       hit;
        logic [4:0] kind;
    } op_match_t;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic op_match_t single_op(input logic [7:0] c);
        op_match_t m;
        m.hit = 1'b1;
        unique case (c)
            "+":     m.kind = KIND_PLUS;
            "-":     m.kind = KIND_MINUS;
            "*":     m.kind = KIND_ASTERISK;
            "/":     m.kind = KIND_SLASH;
            "(":     m.kind = KIND_LPAREN;
            ")":     m.kind = KIND_RPAREN;
            "^":     m.kind = KIND_CARET;
            "|":     m.kind = KIND_PIPE;
            "&":     m.kind = KIND_AMP;
            "~":     m.kind = KIND_TILDE;
            "<":     m.kind = KIND_LANGLE;
            ">":     m.kind = KIND_RANGLE;
            "!":     m.kind = KIND_BANG;
            ",":     m.kind = KIND_COMMA;
            "#":     m.kind = KIND_HASH;
            default:
            begin
                m.hit  = 1'b0;
                m.kind = KIND_INVALID;
            end
        endcase
        return m;
    endfunction

endpackage

FILE: hw/rtl/expression_token_lexer_unit.sv
// Expression token lexer.
// char channel (char_valid/char_ready/char_data): one byte of an expression
// per transaction, or an end marker (end_of_input = 1, char_code ignored).
// token channel (token_valid/token_ready/token_data): one token per
// transaction with kind, number base, start position and length;
// last_of_run marks the last token caused by one char transaction.
// Latency: a token enters the queue when its char transaction is accepted
// and is offered on the token channel the cycle after, if none wait ahead.
// Throughput: one char per cycle while char_ready is high. Tokens go into a
// 4-entry queue, and char_ready stays high while at least two entries are
// free. A byte that yields two tokens needs two pops on the token side, so
// with token_ready high only a sustained run of such bytes pulls char_ready
// low.
// Stall: when token_ready is low, tokens wait in the queue and char_ready
// drops once fewer than two slots remain.
// Reset: the queue empties, the lexer returns to between-tokens with
// position 0. Each end marker also resets position and mode.
module expression_token_lexer_unit #(
    parameter int POSITION_BITS = etl_pkg::POSITION_BITS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             char_valid,
    output logic             char_ready,
    input  etl_pkg::lex_in_t char_data,
    output logic             token_valid,
    input  logic             token_ready,
    output etl_pkg::lex_out_t token_data
);
    import etl_pkg::*;

    localparam int                 PTR_BITS = $clog2(TOKEN_FIFO_DEPTH);
    localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};
    localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

    // one-hot lexer modes
    typedef enum logic [6:0] {
        MODE_IDLE = 7'b0000001,
        MODE_NAME = 7'b0000010,
        MODE_NUM  = 7'b0000100,
        MODE_LT   = 7'b0001000,
        MODE_GT   = 7'b0010000,
        MODE_STAR = 7'b0100000,
        MODE_DEAD = 7'b1000000
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [1:0]               base_reg, base_next;
    logic [POSITION_BITS-1:0] pstart_reg, pstart_next;
    logic [POSITION_BITS-1:0] plen_reg, plen_next;
    logic [POSITION_BITS-1:0] pos_reg, pos_next;

    // token queue
    lex_out_t              fifo_reg [TOKEN_FIFO_DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [PTR_BITS:0]     count_reg;

    function automatic logic [15:0] clip_pos(input logic [POSITION_BITS-1:0] v);
        logic [31:0] wide;
        wide = 32'(v);
        return (wide > 32'h0000_FFFF) ? 16'hFFFF : wide[15:0];
    endfunction

    function automatic logic [POSITION_BITS-1:0] sat_inc(
        input logic [POSITION_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_ONE;
    endfunction

    logic [7:0] c;
    logic       eoi;
    logic       accept;
    logic       pop;

    assign c      = char_data.char_code;
    assign eoi    = char_data.end_of_input;
    assign accept = char_valid && char_ready;
    assign pop    = token_valid && token_ready;

    // pending token that a breaking byte or end marker flushes
    logic     flush_valid;
    lex_out_t flush_tok;

    always_comb
    begin
        flush_valid            = 1'b1;
        flush_tok.number_base  = BASE_DEC;
        flush_tok.token_start  = clip_pos(pstart_reg);
        flush_tok.token_length = 16'd1;
        flush_tok.last_of_run  = 1'b0;
        unique case (mode_reg)
            MODE_NAME:
            begin
                flush_tok.token_kind   = KIND_NAME;
                flush_tok.token_length = clip_pos(plen_reg);
            end
            MODE_NUM:
            begin
                flush_tok.token_kind   = KIND_CONST;
                flush_tok.number_base  = base_reg;
                flush_tok.token_length = clip_pos(plen_reg);
            end
            MODE_LT:   flush_tok.token_kind = KIND_LANGLE;
            MODE_GT:   flush_tok.token_kind = KIND_RANGLE;
            MODE_STAR: flush_tok.token_kind = KIND_ASTERISK;
            default:
            begin
                flush_valid          = 1'b0;
                flush_tok.token_kind = KIND_INVALID;
            end
        endcase
    end

    // what this byte does when lexed from between tokens
    op_match_t  op;
    mode_t      start_mode;
    logic [1:0] start_base;
    logic       start_pending;
    logic       start_emit;
    lex_out_t   start_tok;

    always_comb
    begin
        op                     = single_op(c);
        start_base             = BASE_DEC;
        start_pending          = 1'b1;
        start_emit             = 1'b0;
        start_tok.token_kind   = op.kind;
        start_tok.number_base  = BASE_DEC;
        start_tok.token_start  = clip_pos(pos_reg);
        start_tok.token_length = 16'd1;
        start_tok.last_of_run  = 1'b0;
        priority if (is_alpha(c) || c == CHAR_UNDERSCORE || c == CHAR_DOT)
            start_mode = MODE_NAME;
        else if (is_digit(c) || c == CHAR_DOLLAR || c == CHAR_PERCENT)
        begin
            start_mode = MODE_NUM;
            if (c == CHAR_DOLLAR)
                start_base = BASE_HEX;
            else if (c == CHAR_PERCENT)
                start_base = BASE_BIN;
        end
        else if (c == "<")
            start_mode = MODE_LT;
        else if (c == ">")
            start_mode = MODE_GT;
        else if (c == "*")
            start_mode = MODE_STAR;
        else
        begin
            // single operator, or an unknown byte that kills the expression
            start_pending = 1'b0;
            start_emit    = 1'b1;
            start_mode    = op.hit ? MODE_IDLE : MODE_DEAD;
        end
    end

    // continuation tests and two-character operators
    logic       name_cont, num_cont, pair_hit;
    logic [4:0] pair_kind;

    always_comb
    begin
        name_cont = is_alpha(c) || is_digit(c) || c == CHAR_UNDERSCORE;
        unique case (base_reg)
            BASE_HEX: num_cont = is_hex(c);
            BASE_BIN: num_cont = (c == "0") || (c == "1");
            default:  num_cont = is_digit(c);
        endcase
        num_cont = num_cont || c == CHAR_UNDERSCORE;

        pair_hit  = 1'b0;
        pair_kind = KIND_POWER;
        unique case (mode_reg)
            MODE_LT:
            begin
                pair_hit  = (c == "<");
                pair_kind = KIND_LSHIFT;
            end
            MODE_GT:
            begin
                pair_hit  = (c == ">");
                pair_kind = KIND_RSHIFT;
            end
            MODE_STAR: pair_hit = (c == "*");
            default:   pair_hit = 1'b0;
        endcase
    end

    // main step: token A is the flushed one, token B the new one
    logic     emit_a, emit_b, restart;
    lex_out_t tok_a, tok_b;

    always_comb
    begin
        mode_next   = mode_reg;
        base_next   = base_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        pos_next    = pos_reg;
        emit_a      = 1'b0;
        emit_b      = 1'b0;
        restart     = 1'b0;
        tok_a       = flush_tok;
        tok_b       = start_tok;

        if (eoi)
        begin
            emit_a             = flush_valid;
            emit_b             = 1'b1;
            tok_b.token_kind   = KIND_END;
            tok_b.token_length = 16'd0;
            mode_next          = MODE_IDLE;
            base_next          = BASE_DEC;
            pstart_next        = '0;
            plen_next          = '0;
            pos_next           = '0;
        end
        else
        begin
            pos_next = sat_inc(pos_reg);
            unique case (mode_reg)
                MODE_DEAD: ;
                MODE_NAME:
                    if (name_cont)
                        plen_next = sat_inc(plen_reg);
                    else
                        restart = 1'b1;
                MODE_NUM:
                    if (num_cont)
                        plen_next = sat_inc(plen_reg);
                    else
                        restart = 1'b1;
                MODE_LT, MODE_GT, MODE_STAR:
                    if (pair_hit)
                    begin
                        emit_b             = 1'b1;
                        tok_b.token_kind   = pair_kind;
                        tok_b.token_start  = clip_pos(pstart_reg);
                        tok_b.token_length = 16'd2;
                        mode_next          = MODE_IDLE;
                        pstart_next        = '0;
                        plen_next          = '0;
                    end
                    else
                        restart = 1'b1;
                default: restart = 1'b1;
            endcase

            if (restart)
            begin
                emit_a      = flush_valid;
                emit_b      = start_emit;
                mode_next   = start_mode;
                base_next   = start_base;
                pstart_next = start_pending ? pos_reg : '0;
                plen_next   = start_pending ? POS_ONE : '0;
            end
        end
    end

    // pack into queue slots in emission order
    lex_out_t   slot0, slot1;
    logic [1:0] push_n;

    always_comb
    begin
        slot0             = emit_a ? tok_a : tok_b;
        slot0.last_of_run = !(emit_a && emit_b);
        slot1             = tok_b;
        slot1.last_of_run = 1'b1;
        push_n            = accept ? (2'(emit_a) + 2'(emit_b)) : 2'd0;
    end

    assign char_ready  = count_reg < (PTR_BITS+1)'(TOKEN_FIFO_DEPTH - 1);
    assign token_valid = count_reg != '0;
    assign token_data  = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            base_reg   <= BASE_DEC;
            pstart_reg <= '0;
            plen_reg   <= '0;
            pos_reg    <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg   <= mode_next;
                base_reg   <= base_next;
                pstart_reg <= pstart_next;
                plen_reg   <= plen_next;
                pos_reg    <= pos_next;
            end
            wr_ptr_reg <= wr_ptr_reg + PTR_BITS'(push_n);
            rd_ptr_reg <= rd_ptr_reg + PTR_BITS'(pop);
            count_reg  <= count_reg + (PTR_BITS+1)'(push_n) - (PTR_BITS+1)'(pop);
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
            fifo_reg[wr_ptr_reg] <= slot0;
        if (push_n == 2'd2)
            fifo_reg[wr_ptr_reg + PTR_BITS'(1)] <= slot1;
    end

endmodule

FILE: hw/rtl/etl_checker.sv
`include "expression_token_lexer_unit_macros.svh"

module etl_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              char_valid,
    input logic              char_ready,
    input etl_pkg::lex_in_t  char_data,
    input logic              token_valid,
    input logic              token_ready,
    input etl_pkg::lex_out_t token_data
);
    import etl_pkg::*;

    // a stalled token stays offered
    `ETL_ASSERT_NXT(a_token_hold, token_valid && !token_ready, token_valid)

    // an accepted end marker always leaves a token offered on the next cycle
    `ETL_ASSERT_NXT(a_end_token, char_valid && char_ready && char_data.end_of_input,
                    token_valid)

    // only the end token has zero length
    `ETL_ASSERT_IMP(a_zero_len, token_valid,
                    (token_data.token_kind == KIND_END) == (token_data.token_length == 16'd0))

    // base is reported only on constants
    `ETL_ASSERT_IMP(a_base_const, token_valid && token_data.token_kind != KIND_CONST,
                    token_data.number_base == BASE_DEC)

endmodule

bind expression_token_lexer_unit etl_checker u_etl_checker (.*);
